[sv/dcr_pkg.sv]
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types and character codes for the digit display refresh core.
// ----------------------------------------------------------------------------
package dcr_pkg;

  // character codes recognized in the number text
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // cache content of a position that was never written
  localparam logic [3:0] INVALID_DIGIT = 4'd15;

  // reset value of the position count register
  localparam logic [3:0] DIGIT_COUNT_RESET = 4'd8;

  // controller to datapath commands
  typedef struct packed {
    logic collect;  // take the accepted character into the text buffer
    logic load;     // capture the display id and start a new scan
    logic step;     // look up the next position
    logic flush;    // send the held write as the last one, clear the string
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;  // every position has been looked up
  } status_t;

endpackage

[sv/digit_display_change_refresh_core.sv]
// ----------------------------------------------------------------------------
// digit_display_change_refresh_core
// Number text to seven-segment digit writes with a per-display change cache.
// ----------------------------------------------------------------------------
// A character item is taken when start is high and busy is low. The final
// one starts a refresh that looks up one position a cycle in the display
// cache, for min(digit_count, MAX_POSITIONS) positions, while busy stays high.
// Each changed position gives one write item on the output ports, marked by
// strobe for exactly one cycle; the receiver cannot stall, so every strobed
// item must be taken when shown. The last write of a refresh carries
// last_write. The cache keeps one valid bit per entry, so reset takes effect
// at once.
module digit_display_change_refresh_core #(
  parameter int DISPLAY_COUNT = 8,
  parameter int MAX_POSITIONS = 8,
  parameter int TEXT_DIGITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [3:0] wr_data,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] display_id,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       strobe,
  output logic [2:0] target_display,
  output logic [2:0] position,
  output logic [3:0] digit_value,
  output logic       point_on,
  output logic       last_write
);

  dcr_pkg::cmd_t    cmd;
  dcr_pkg::status_t status;

  // sequencer
  dcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_char (last_char),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // buffers, cache and output
  dcr_datapath #(
    .DISPLAY_COUNT (DISPLAY_COUNT),
    .MAX_POSITIONS (MAX_POSITIONS),
    .TEXT_DIGITS   (TEXT_DIGITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .wr_en          (wr_en),
    .wr_data        (wr_data),
    .display_id     (display_id),
    .char_code      (char_code),
    .strobe         (strobe),
    .target_display (target_display),
    .position       (position),
    .digit_value    (digit_value),
    .point_on       (point_on),
    .last_write     (last_write)
  );

  // no write item comes out of an idle cycle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst) !busy |=> !strobe)
    else $error("write item after an idle cycle");

  // a write that is not the last one belongs to a refresh still running
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_write |-> busy)
    else $error("non-final write outside a refresh");

  // the last write ends the refresh
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_write |=> !strobe)
    else $error("activity after the last write");

  // positions stay inside the display
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (4'(position) < 4'(MAX_POSITIONS)))
    else $error("position beyond the display");

endmodule

[sv/dcr_ctrl.sv]
// ----------------------------------------------------------------------------
// dcr_ctrl
// Sequencer: accepts items, steps through the positions of a refresh, flushes.
// ----------------------------------------------------------------------------
module dcr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last_char,
  input  dcr_pkg::status_t status,
  output dcr_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FLUSH
  } state_t;

  state_t state;
  logic   accept;

  assign accept = start && !busy;

  // commands decoded from the current state and the item handshake
  always_comb begin
    cmd.collect = accept;
    cmd.load    = accept && last_char;
    cmd.step    = (state == SCAN) && !status.scan_done;
    cmd.flush   = (state == FLUSH);
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept && last_char) begin
            state <= SCAN;
            busy  <= 1'b1;
          end
        end
        SCAN: begin
          if (status.scan_done) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

[sv/dcr_datapath.sv]
// ----------------------------------------------------------------------------
// dcr_datapath
// Text buffer, position scan, per-display cache memory and write output.
// ----------------------------------------------------------------------------
module dcr_datapath #(
  parameter int DISPLAY_COUNT = 8,
  parameter int MAX_POSITIONS = 8,
  parameter int TEXT_DIGITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  dcr_pkg::cmd_t    cmd,
  output dcr_pkg::status_t status,
  input  logic             wr_en,
  input  logic [3:0]       wr_data,
  input  logic [2:0]       display_id,
  input  logic [7:0]       char_code,
  output logic             strobe,
  output logic [2:0]       target_display,
  output logic [2:0]       position,
  output logic [3:0]       digit_value,
  output logic             point_on,
  output logic             last_write
);

  localparam int CW          = $clog2(TEXT_DIGITS + 1);
  localparam int IW          = $clog2(TEXT_DIGITS);
  localparam int XW          = CW + 2;
  localparam int CACHE_DEPTH = DISPLAY_COUNT * MAX_POSITIONS;
  localparam int SW          = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  // configuration and collected text
  logic [3:0]    digit_count;
  logic [3:0]    digit_buffer [TEXT_DIGITS];
  logic [CW-1:0] digit_total;
  logic          point_valid;
  logic [IW-1:0] point_after_index;

  // scan state
  logic [2:0]    disp;
  logic          cached;
  logic [3:0]    pos_cnt;
  logic [3:0]    positions;

  // cache memory and its valid bits
  logic [4:0]             cache_mem [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] cache_valid;

  // lookup stage
  logic          s1_valid;
  logic [2:0]    s1_pos;
  logic [SW-1:0] s1_slot;
  logic [3:0]    s1_dig;
  logic          s1_pt;
  logic          s1_cvalid;
  logic [4:0]    s1_mem;

  // held write, sent once the next one or the end is known
  logic          hold_valid;
  logic [2:0]    hold_pos;
  logic [3:0]    hold_dig;
  logic          hold_pt;

  logic signed [XW-1:0] idx;
  logic [XW-1:0]        idx_u;
  logic                 idx_nonneg;
  logic                 in_range;
  logic [SW-1:0]        slot;
  logic [4:0]           shown;
  logic                 changed;
  logic                 is_digit;

  // position count limited to the storage
  always_comb begin
    if (digit_count > 4'(MAX_POSITIONS)) begin
      positions = 4'(MAX_POSITIONS);
    end else begin
      positions = digit_count;
    end
  end

  assign status.scan_done = (pos_cnt == positions);

  // text index of the position being looked up, right-aligned
  assign idx        = XW'(pos_cnt) + XW'(digit_total) - XW'(positions);
  assign idx_u      = idx;
  assign idx_nonneg = !idx[XW-1];
  assign in_range   = idx_nonneg && (idx_u < XW'(digit_total));
  assign slot       = SW'(disp) * SW'(MAX_POSITIONS) + SW'(pos_cnt);

  assign is_digit = (char_code >= dcr_pkg::CHAR_ZERO) && (char_code <= dcr_pkg::CHAR_NINE);

  // compare against the shown content
  assign shown   = s1_cvalid ? s1_mem : {dcr_pkg::INVALID_DIGIT, 1'b0};
  assign changed = !cached || (shown != {s1_dig, s1_pt});

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= dcr_pkg::DIGIT_COUNT_RESET;
    end else if (wr_en) begin
      digit_count <= wr_data;
    end
  end

  // digit buffer entries
  always_ff @(posedge clk) begin
    if (cmd.collect && is_digit && (digit_total < CW'(TEXT_DIGITS))) begin
      digit_buffer[digit_total[IW-1:0]] <= 4'(char_code - dcr_pkg::CHAR_ZERO);
    end
  end

  // digit count and point marker
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_total       <= '0;
      point_valid       <= 1'b0;
      point_after_index <= '0;
    end else if (cmd.flush) begin
      digit_total       <= '0;
      point_valid       <= 1'b0;
      point_after_index <= '0;
    end else if (cmd.collect) begin
      if (char_code == dcr_pkg::CHAR_POINT) begin
        if (digit_total != '0) begin
          point_valid       <= 1'b1;
          point_after_index <= IW'(digit_total - CW'(1));
        end else begin
          point_valid       <= 1'b0;
          point_after_index <= '0;
        end
      end else if (is_digit && (digit_total < CW'(TEXT_DIGITS))) begin
        digit_total <= digit_total + CW'(1);
      end
    end
  end

  // scan position counter and target display
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
    end else if (cmd.load) begin
      pos_cnt <= '0;
    end else if (cmd.step) begin
      pos_cnt <= pos_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      disp   <= display_id;
      cached <= (5'(display_id) < 5'(DISPLAY_COUNT));
    end
  end

  // lookup: buffer digit, point, cache entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      s1_pos    <= pos_cnt[2:0];
      s1_slot   <= slot;
      s1_dig    <= in_range ? digit_buffer[idx_u[IW-1:0]] : 4'd0;
      s1_pt     <= point_valid && idx_nonneg && (idx_u == XW'(point_after_index));
      s1_cvalid <= cached && cache_valid[slot];
      s1_mem    <= cache_mem[slot];
    end
  end

  // cache update on change
  always_ff @(posedge clk) begin
    if (s1_valid && cached && changed) begin
      cache_mem[s1_slot] <= {s1_dig, s1_pt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_valid <= '0;
    end else if (s1_valid && cached && changed) begin
      cache_valid[s1_slot] <= 1'b1;
    end
  end

  // held write and output item
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      strobe     <= 1'b0;
    end else if (s1_valid && changed) begin
      strobe     <= hold_valid;
      hold_valid <= 1'b1;
    end else if (cmd.flush) begin
      strobe     <= hold_valid;
      hold_valid <= 1'b0;
    end else begin
      strobe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && changed) begin
      hold_pos       <= s1_pos;
      hold_dig       <= s1_dig;
      hold_pt        <= s1_pt;
      target_display <= disp;
      position       <= hold_pos;
      digit_value    <= hold_dig;
      point_on       <= hold_pt;
      last_write     <= 1'b0;
    end else if (cmd.flush) begin
      target_display <= disp;
      position       <= hold_pos;
      digit_value    <= hold_dig;
      point_on       <= hold_pt;
      last_write     <= 1'b1;
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the digit display refresh core. Number strings are
// fed one character per item. A local model keeps its own text buffer and
// display caches, and predicts the digit writes of every refresh. The writes
// seen on the output side are matched in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DISPLAY_COUNT = 8;
  localparam int MAX_POSITIONS = 8;
  localparam int TEXT_DIGITS   = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;

  // one character item as sent to the core
  typedef struct packed {
    logic [2:0] disp;
    logic [7:0] code;
    logic       last;
  } char_item_t;

  // one digit write as produced by the core
  typedef struct packed {
    logic [2:0] disp;
    logic [2:0] pos;
    logic [3:0] digit;
    logic       point;
    logic       last;
  } digit_write_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wr_en = 1'b0;
  logic [3:0] wr_data = '0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] display_id = '0;
  logic [7:0] char_code = '0;
  logic       last_char = 1'b0;
  logic       strobe;
  logic [2:0] target_display;
  logic [2:0] position;
  logic [3:0] digit_value;
  logic       point_on;
  logic       last_write;

  // pending characters and predicted digit writes
  char_item_t   char_queue[$];
  digit_write_t pending_writes[$];
  char_item_t   cur_char;
  bit [7:0]     text_scratch[$];
  bit [7:0]     prev_text[$];
  bit [2:0]     prev_disp;
  int           idle_pct = 33;
  int           counted_items;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  // model state of the text collector and the display caches
  bit [3:0] text_digits[TEXT_DIGITS];
  int       text_len = 0;
  bit       pt_valid = 1'b0;
  int       pt_index = 0;
  bit [3:0] shown_digit[DISPLAY_COUNT][MAX_POSITIONS];
  bit       shown_point[DISPLAY_COUNT][MAX_POSITIONS];
  bit [3:0] count_setting = dcr_pkg::DIGIT_COUNT_RESET;

  digit_display_change_refresh_core #(
    .DISPLAY_COUNT(DISPLAY_COUNT),
    .MAX_POSITIONS(MAX_POSITIONS),
    .TEXT_DIGITS  (TEXT_DIGITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_data       (wr_data),
    .start         (start),
    .busy          (busy),
    .display_id    (display_id),
    .char_code     (char_code),
    .last_char     (last_char),
    .strobe        (strobe),
    .target_display(target_display),
    .position      (position),
    .digit_value   (digit_value),
    .point_on      (point_on),
    .last_write    (last_write)
  );

  always #1 clk = ~clk;

  // collect one character, and on the final one predict the changed digits
  task automatic collect_and_refresh(input char_item_t it);
    int npos, pad, idx, p, n, i;
    bit [3:0] dig;
    bit pt, changed, cached;
    digit_write_t w[MAX_POSITIONS];
    if (it.code == dcr_pkg::CHAR_POINT) begin
      pt_valid = (text_len > 0);
      pt_index = (text_len > 0) ? text_len - 1 : 0;
    end else if (it.code >= dcr_pkg::CHAR_ZERO && it.code <= dcr_pkg::CHAR_NINE) begin
      if (text_len < TEXT_DIGITS) begin
        text_digits[text_len] = 4'(it.code - dcr_pkg::CHAR_ZERO);
        text_len++;
      end
    end
    if (it.last) begin
      npos = (count_setting > MAX_POSITIONS) ? MAX_POSITIONS : int'(count_setting);
      pad = npos - text_len;
      cached = (int'(it.disp) < DISPLAY_COUNT);
      n = 0;
      for (p = 0; p < npos; p++) begin
        idx = p - pad;
        dig = (idx >= 0 && idx < text_len) ? text_digits[idx] : 4'd0;
        pt = pt_valid && idx >= 0 && idx == pt_index;
        changed = 1'b1;
        if (cached) begin
          changed = (shown_digit[it.disp][p] != dig) || (shown_point[it.disp][p] != pt);
          if (changed) begin
            shown_digit[it.disp][p] = dig;
            shown_point[it.disp][p] = pt;
          end
        end
        if (changed) begin
          w[n] = {it.disp, 3'(p), dig, pt, 1'b0};
          n++;
        end
      end
      if (n > 0) w[n-1].last = 1'b1;
      for (i = 0; i < n; i++) pending_writes.push_back(w[i]);
      text_len = 0;
      pt_valid = 1'b0;
      pt_index = 0;
    end
  endtask

  // move the scratch text into the character queue, final flag on the end
  task automatic queue_scratch(input bit [2:0] disp, input bit mix);
    int i;
    char_item_t it;
    for (i = 0; i < text_scratch.size(); i++) begin
      it.code = text_scratch[i];
      it.last = (i == text_scratch.size() - 1);
      it.disp = (mix && !it.last) ? 3'($urandom_range(7)) : disp;
      if (it.last || it.code == dcr_pkg::CHAR_POINT ||
          (it.code >= dcr_pkg::CHAR_ZERO && it.code <= dcr_pkg::CHAR_NINE)) counted_items++;
      char_queue.push_back(it);
    end
  endtask

  task automatic queue_text(input bit [2:0] disp, input string txt, input bit mix);
    int i;
    text_scratch.delete();
    for (i = 0; i < txt.len(); i++) text_scratch.push_back(txt[i]);
    queue_scratch(disp, mix);
  endtask

  // one random number string: mostly well formed, some noise and repeats
  task automatic queue_random_text();
    int kind, ndig, pt_at, i;
    bit [2:0] d;
    bit [7:0] c;
    kind = $urandom_range(15);
    d = 3'($urandom_range(7));
    text_scratch.delete();
    if (kind == 0) begin
      repeat ($urandom_range(6, 1)) begin
        c = 8'($urandom_range(255));
        text_scratch.push_back(c);
      end
    end else if (kind == 1 && prev_text.size() > 0) begin
      // same text again on the same display, usually nothing changes
      text_scratch = prev_text;
      d = prev_disp;
    end else begin
      ndig = (kind == 2) ? $urandom_range(20, 17) : $urandom_range(9);
      pt_at = $urandom_range(1) ? $urandom_range(ndig) : -1;
      for (i = 0; i <= ndig; i++) begin
        if (i == pt_at) text_scratch.push_back(dcr_pkg::CHAR_POINT);
        if (i < ndig) begin
          c = dcr_pkg::CHAR_ZERO + 8'($urandom_range(9));
          text_scratch.push_back(c);
        end
        if ($urandom_range(11) == 0) begin
          c = 8'($urandom_range(255));
          text_scratch.push_back(c);
        end
      end
      if ($urandom_range(7) == 0) text_scratch.push_back(dcr_pkg::CHAR_POINT);
      if (text_scratch.size() == 0) begin
        c = 8'($urandom_range(255));
        text_scratch.push_back(c);
      end
    end
    prev_text = text_scratch;
    prev_disp = d;
    queue_scratch(d, $urandom_range(7) == 0);
  endtask

  // wait until every character is taken and every write has come out
  task automatic wait_quiet();
    while (char_queue.size() != 0 || start || pending_writes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_digit_count(input bit [3:0] value);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_data <= value;
    count_setting = value;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic run_phase(input bit [3:0] count, input int idle, input int n_items);
    wait_quiet();
    set_digit_count(count);
    idle_pct = idle;
    counted_items = 0;
    while (counted_items < n_items) queue_random_text();
  endtask

  // character driver
  always @(posedge clk) begin : drive_chars
    char_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) collect_and_refresh(cur_char);
      if (start && busy) begin
        // item held until taken
      end else if (char_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = char_queue.pop_front();
        cur_char = nxt;
        start <= 1'b1;
        display_id <= nxt.disp;
        char_code <= nxt.code;
        last_char <= nxt.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // digit write checker, sampled mid-cycle
  always @(negedge clk) begin : check_writes
    digit_write_t got, want;
    if (!rst && strobe) begin
      got = {target_display, position, digit_value, point_on, last_write};
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write disp %0d pos %0d digit %0d point %0b last %0b",
                 $realtime, got.disp, got.pos, got.digit, got.point, got.last);
        mismatch_count++;
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) begin
          $display("%0t: write mismatch, expected disp %0d pos %0d digit %0d point %0b last %0b",
                   $realtime, want.disp, want.pos, want.digit, want.point, want.last);
          $display("%0t:                 actual   disp %0d pos %0d digit %0d point %0b last %0b",
                   $realtime, got.disp, got.pos, got.digit, got.point, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // run time limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : run
    int d, p;
    for (d = 0; d < DISPLAY_COUNT; d++) begin
      for (p = 0; p < MAX_POSITIONS; p++) begin
        shown_digit[d][p] = dcr_pkg::INVALID_DIGIT;
        shown_point[d][p] = 1'b0;
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed strings at the reset digit count
    queue_text(3'd0, "12.5", 1'b0);                // first frame writes all
    queue_text(3'd0, "12.5", 1'b0);                // no change
    text_scratch.delete();
    text_scratch.push_back(8'h00);
    text_scratch.push_back("9");
    text_scratch.push_back(8'hFF);                 // ignored final char
    queue_scratch(3'd7, 1'b0);
    queue_text(3'd3, ".7.", 1'b0);                 // point before any digit
    queue_text(3'd5, "1.2.3", 1'b1);               // last point wins, mixed ids
    queue_text(3'd2, "Z", 1'b0);                   // empty string
    queue_text(3'd2, "98765432", 1'b0);

    // random strings over several digit counts
    run_phase(4'd1, 33, 20);
    run_phase(4'd0, 33, 10);
    run_phase(4'd15, 88, 20);
    run_phase(4'd5, 88, 20);
    run_phase(4'd8, 0, 25);

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
